/* rtl/nta_pkg.sv */
package nta_pkg;

	localparam int unsigned ValW      = 32;
	localparam int unsigned KindW     = 3;
	localparam int unsigned CharW     = 8;
	localparam int unsigned DigW      = 4;
	localparam int unsigned NumDig    = 10;
	localparam int unsigned DigIdxW   = $clog2(NumDig);
	localparam int unsigned FifoDepth = 2;

	// floor(v / 10) == (v * Recip10) >> Recip10Shift for every 32-bit v
	localparam logic [ValW-1:0] Recip10      = 32'hCCCC_CCCD;
	localparam int unsigned     Recip10Shift = 35;

	localparam logic [CharW-1:0] CharSpace   = 8'h20;
	localparam logic [CharW-1:0] CharZero    = 8'h30;
	localparam logic [CharW-1:0] CharHexBase = 8'h41 - 8'd10;

	localparam logic [DigIdxW-1:0] HexDig8  = DigIdxW'(2);
	localparam logic [DigIdxW-1:0] HexDig16 = DigIdxW'(4);
	localparam logic [DigIdxW-1:0] HexDig32 = DigIdxW'(8);

	typedef enum logic [KindW-1:0] {
		KIND_HEX8  = 3'd0,
		KIND_HEX16 = 3'd1,
		KIND_HEX32 = 3'd2,
		KIND_DEC8  = 3'd3,
		KIND_DEC16 = 3'd4,
		KIND_DEC32 = 3'd5
	} kind_t;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [ValW-1:0]  value;
	} item_t;

	typedef struct packed {
		logic [CharW-1:0] char_code;
		logic             last;
	} result_t;

	// classified work for the back end
	typedef struct packed {
		logic               dec;
		logic               pre;
		logic [DigIdxW-1:0] hex_dig;
		logic [ValW-1:0]    value;
	} desc_t;

	function automatic logic [CharW-1:0] nibble_char(input logic [DigW-1:0] n);
		logic [CharW-1:0] w;
		w = CharW'(n);
		if (n >= DigW'(10)) begin
			return w + CharHexBase;
		end
		return w + CharZero;
	endfunction

endpackage

/* rtl/number_to_ascii_formatter.sv */
// Formats each transfer of {kind, value} as a run of ASCII characters, one character per
// result transfer, last set on the final one: upper-case hex (2, 4 or 8 digits, a space ahead
// of 16- and 32-bit) or decimal with a leading space and no leading zeros. Kinds 6 and 7 are
// taken and yield nothing. The output issues one character per cycle unless stalled;
// in parallel, a converter makes decimal digits at one per cycle with a reciprocal multiply,
// and loads hex digits all at once. A small queue between the input classifier and the
// converter lets input keep flowing while a run drains.
module number_to_ascii_formatter #(
	parameter int unsigned FIFO_DEPTH = nta_pkg::FifoDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  nta_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output nta_pkg::result_t result
);
	import nta_pkg::*;

	desc_t f_desc;
	desc_t q_desc;
	logic  push;
	logic  push_ready;
	logic  q_valid;
	logic  pop;

	nta_front u_front (
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.desc       (f_desc),
		.push       (push),
		.push_ready (push_ready)
	);

	nta_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (f_desc),
		.push_ready (push_ready),
		.pop_valid  (q_valid),
		.pop_data   (q_desc),
		.pop        (pop)
	);

	nta_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.desc_valid   (q_valid),
		.desc         (q_desc),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

/* rtl/nta_front.sv */
module nta_front (
	input  nta_pkg::item_t item,
	input  logic           item_valid,
	output logic           item_ready,
	output nta_pkg::desc_t desc,
	output logic           push,
	input  logic           push_ready
);
	import nta_pkg::*;

	logic keep;

	always_comb begin
		keep         = 1'b1;
		desc.dec     = 1'b0;
		desc.pre     = 1'b1;
		desc.hex_dig = HexDig32;
		desc.value   = item.value;
		case (kind_t'(item.kind))
			KIND_HEX8: begin
				desc.pre     = 1'b0;
				desc.hex_dig = HexDig8;
				desc.value   = ValW'(item.value[7:0]);
			end
			KIND_HEX16: begin
				desc.hex_dig = HexDig16;
				desc.value   = ValW'(item.value[15:0]);
			end
			KIND_HEX32: begin
				desc.hex_dig = HexDig32;
			end
			KIND_DEC8: begin
				desc.dec   = 1'b1;
				desc.value = ValW'(item.value[7:0]);
			end
			KIND_DEC16: begin
				desc.dec   = 1'b1;
				desc.value = ValW'(item.value[15:0]);
			end
			KIND_DEC32: begin
				desc.dec = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// unused kinds are taken and dropped
	assign item_ready = push_ready;
	assign push       = item_valid && push_ready && keep;

endmodule

/* rtl/nta_fifo.sv */
module nta_fifo #(
	parameter int unsigned DEPTH = nta_pkg::FifoDepth
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nta_pkg::desc_t push_data,
	output logic           push_ready,
	output logic           pop_valid,
	output nta_pkg::desc_t pop_data,
	input  logic           pop
);
	import nta_pkg::*;

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	desc_t           mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		if (p == PtrW'(DEPTH - 1)) begin
			return '0;
		end
		return p + PtrW'(1);
	endfunction

	assign push_ready = cnt_q != CntW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/nta_back.sv */
module nta_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             desc_valid,
	input  nta_pkg::desc_t   desc,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_ready,
	output nta_pkg::result_t result
);
	import nta_pkg::*;

	// converter: hex loads nibbles at once, decimal peels one digit per cycle, LSB first
	logic               cv_valid_q;
	logic               cv_done_q;
	logic               cv_pre_q;
	logic [ValW-1:0]    cv_v_q;
	logic [DigIdxW-1:0] cv_ndig_q;
	logic [DigW-1:0]    cv_dig_q [NumDig];

	// emitter: space (optional), then digits from the top index down
	logic               em_valid_q;
	logic               em_pre_q;
	logic [DigIdxW-1:0] em_idx_q;
	logic [DigW-1:0]    em_dig_q [NumDig];

	logic [2*ValW-1:0]        prod;
	logic [ValW-1:0]          quot;
	logic [ValW-1:0]          quot_x10;
	logic [DigW-1:0]          rem;
	logic [NumDig*DigW-1:0]   nib_wide;
	logic                     xfer;
	logic                     em_free;
	logic                     handoff;

	assign prod     = cv_v_q * Recip10;
	assign quot     = ValW'(prod >> Recip10Shift);
	assign quot_x10 = (quot << 3) + (quot << 1);
	assign rem      = DigW'(cv_v_q - quot_x10);
	assign nib_wide = (NumDig*DigW)'(desc.value);

	assign xfer    = result_valid && result_ready;
	assign em_free = !em_valid_q || (xfer && result.last);
	assign handoff = cv_valid_q && cv_done_q && em_free;
	assign pop     = desc_valid && (!cv_valid_q || handoff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_valid_q <= 1'b0;
			cv_done_q  <= 1'b0;
		end else begin
			if (pop) begin
				cv_valid_q <= 1'b1;
				cv_done_q  <= !desc.dec;
			end else if (handoff) begin
				cv_valid_q <= 1'b0;
			end else if (cv_valid_q && !cv_done_q && quot == '0) begin
				cv_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cv_pre_q <= desc.pre;
			cv_v_q   <= desc.value;
			cv_ndig_q <= desc.dec ? '0 : desc.hex_dig;
			for (int i = 0; i < NumDig; i++) begin
				cv_dig_q[i] <= nib_wide[i*DigW +: DigW];
			end
		end else if (cv_valid_q && !cv_done_q) begin
			for (int i = 0; i < NumDig; i++) begin
				if (cv_ndig_q == DigIdxW'(i)) begin
					cv_dig_q[i] <= rem;
				end
			end
			cv_ndig_q <= cv_ndig_q + DigIdxW'(1);
			cv_v_q    <= quot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_valid_q <= 1'b0;
			em_pre_q   <= 1'b0;
			em_idx_q   <= '0;
		end else begin
			if (handoff) begin
				em_valid_q <= 1'b1;
				em_pre_q   <= cv_pre_q;
				em_idx_q   <= cv_ndig_q - DigIdxW'(1);
			end else if (xfer) begin
				if (em_pre_q) begin
					em_pre_q <= 1'b0;
				end else if (em_idx_q == '0) begin
					em_valid_q <= 1'b0;
				end else begin
					em_idx_q <= em_idx_q - DigIdxW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (handoff) begin
			em_dig_q <= cv_dig_q;
		end
	end

	assign result_valid     = em_valid_q;
	assign result.char_code = em_pre_q ? CharSpace : nibble_char(em_dig_q[em_idx_q]);
	assign result.last      = !em_pre_q && em_idx_q == '0;

	a_conv_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cv_valid_q && !cv_done_q |-> cv_ndig_q < DigIdxW'(NumDig))
		else $error("converter ran past the digit store");

	a_handoff_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		handoff |-> cv_ndig_q != '0 && cv_ndig_q <= DigIdxW'(NumDig))
		else $error("handoff with bad digit count");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		em_valid_q |-> em_idx_q < DigIdxW'(NumDig))
		else $error("emitter index out of range");

endmodule

/* tb/number_to_ascii_formatter_test.sv */
`timescale 1ns / 1ps

module number_to_ascii_formatter_test;
	import nta_pkg::*;

	localparam logic [KindW-1:0] KIND_SPARE6 = 3'd6;
	localparam logic [KindW-1:0] KIND_SPARE7 = 3'd7;
	localparam byte AsciiZero = "0";
	localparam byte AsciiA    = "A";
	localparam int  IdleLimit = 1000;
	localparam int  TailCycles = 30;
	localparam int  RandomItems = 235;

	typedef struct {
		logic [KindW-1:0] kind;
		logic [ValW-1:0]  value;
		bit               fixed;
		string            text;
	} row_t;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	result_t chars_due[$];
	row_t    rows[$];
	bit      use_fixed;
	string   fixed_text;
	int      mismatches = 0;
	int      idle_cycles = 0;
	int      burst_left;

	number_to_ascii_formatter DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// character run for one item; empty for the spare kinds
	function automatic string format_number(logic [KindW-1:0] kind, logic [ValW-1:0] value);
		string      s;
		int         nibbles;
		logic [3:0] nib;
		byte        ch;
		s = "";
		nibbles = 0;
		case (kind)
			KIND_HEX8: nibbles = 2;
			KIND_HEX16: begin
				s = " ";
				nibbles = 4;
			end
			KIND_HEX32: begin
				s = " ";
				nibbles = 8;
			end
			KIND_DEC8:  s = $sformatf(" %0d", value[7:0]);
			KIND_DEC16: s = $sformatf(" %0d", value[15:0]);
			KIND_DEC32: s = $sformatf(" %0d", value);
			default: ;
		endcase
		for (int i = nibbles - 1; i >= 0; i--) begin
			nib = value[4*i +: 4];
			ch = (nib < 4'd10) ? AsciiZero + nib : AsciiA + nib - 8'd10;
			s = $sformatf("%s%c", s, ch);
		end
		return s;
	endfunction

	function automatic void add_row(logic [KindW-1:0] kind, logic [ValW-1:0] value,
			bit fixed, string text);
		row_t r;
		r.kind = kind;
		r.value = value;
		r.fixed = fixed;
		r.text = text;
		rows.push_back(r);
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic offer_item(item_t it, bit fixed, string text);
		if (burst_left == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		item <= it;
		item_valid <= 1'b1;
		use_fixed = fixed;
		fixed_text = text;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic drain_output();
		item_valid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (chars_due.size() != 0);
	endtask

	// receiver stall pattern: stretches of always-ready, mostly-ready, periodic and long stalls
	initial begin
		int mode;
		int span;
		result_ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(5, 40);
			for (int step = 0; step < span; step++) begin
				@(negedge clk);
				case (mode)
					0: result_ready <= 1'b1;
					1: result_ready <= ($urandom_range(0, 3) != 0);
					2: result_ready <= (step % 3 != 0);
					default: result_ready <= (step == span - 1);
				endcase
			end
		end
	end

	// predict on input transfers, then check output transfers, in one process
	always @(posedge clk) begin : scoreboard
		string   text;
		result_t want;
		bit      stray;
		if (arst_n && item_valid && item_ready) begin
			text = use_fixed ? fixed_text : format_number(item.kind, item.value);
			for (int i = 0; i < text.len(); i++) begin
				want.char_code = text[i];
				want.last = (i == text.len() - 1);
				chars_due.push_back(want);
			end
		end
		if (arst_n && result_valid && result_ready) begin
			stray = (chars_due.size() == 0);
			want = stray ? '0 : chars_due.pop_front();
			if (stray || result !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					if (stray)
						$display("unexpected char %h last %b", result.char_code, result.last);
					else
						$display("mismatch: expected char %h last %b, got char %h last %b",
							want.char_code, want.last, result.char_code, result.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		item_t            it;
		logic [KindW-1:0] kind;
		logic [ValW-1:0]  value;
		logic [ValW-1:0]  pow;
		int               issued;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		use_fixed = 1'b0;
		fixed_text = "";
		burst_left = 0;

		add_row(KIND_HEX8,   32'h0000_0000, 1, "00");
		add_row(KIND_HEX8,   32'h0000_00FF, 1, "FF");
		add_row(KIND_HEX8,   32'hFFFF_FF5A, 1, "5A");
		add_row(KIND_HEX16,  32'h0000_0000, 1, " 0000");
		add_row(KIND_HEX16,  32'h0000_FFFF, 1, " FFFF");
		add_row(KIND_HEX16,  32'h1234_89AB, 0, "");
		add_row(KIND_HEX32,  32'h0000_0000, 1, " 00000000");
		add_row(KIND_HEX32,  32'hFFFF_FFFF, 1, " FFFFFFFF");
		add_row(KIND_HEX32,  32'h0123_ABCD, 1, " 0123ABCD");
		add_row(KIND_DEC8,   32'd0,         1, " 0");
		add_row(KIND_DEC8,   32'd100,       1, " 100");
		add_row(KIND_DEC8,   32'd255,       1, " 255");
		add_row(KIND_DEC8,   32'hFFFF_FF09, 1, " 9");
		add_row(KIND_DEC8,   32'd99,        0, "");
		add_row(KIND_DEC16,  32'd0,         1, " 0");
		add_row(KIND_DEC16,  32'd65535,     1, " 65535");
		add_row(KIND_DEC16,  32'hABCD_0000, 1, " 0");
		add_row(KIND_DEC16,  32'd10000,     0, "");
		add_row(KIND_DEC32,  32'd0,         1, " 0");
		add_row(KIND_DEC32,  32'hFFFF_FFFF, 1, " 4294967295");
		add_row(KIND_DEC32,  32'd1000000000, 1, " 1000000000");
		add_row(KIND_DEC32,  32'd999999999, 0, "");
		add_row(KIND_DEC32,  32'd10,        0, "");
		add_row(KIND_SPARE6, 32'hFFFF_FFFF, 1, "");
		add_row(KIND_SPARE7, 32'h0000_0000, 1, "");

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			it.kind = rows[i].kind;
			it.value = rows[i].value;
			offer_item(it, rows[i].fixed, rows[i].text);
		end
		drain_output();

		issued = 0;
		while (issued < RandomItems) begin
			if ($urandom_range(0, 19) == 0)
				kind = $urandom_range(KIND_SPARE6, KIND_SPARE7);
			else
				kind = $urandom_range(KIND_HEX8, KIND_DEC32);
			case ($urandom_range(0, 4))
				0: value = $urandom;
				1: value = $urandom_range(0, 300);
				2: begin
					// just around a power of ten
					pow = 1;
					repeat ($urandom_range(0, 9)) pow = pow * 10;
					value = pow - 1 + $urandom_range(0, 2);
				end
				3: value = $urandom >> $urandom_range(0, 31);
				default: value = ($urandom & 32'hFFFF_0000) | $urandom_range(0, 255);
			endcase
			it.kind = kind;
			it.value = value;
			offer_item(it, 0, "");
			if (kind <= KIND_DEC32) begin
				issued++;
				if (issued == RandomItems / 2)
					drain_output();
			end
		end

		drain_output();
		repeat (TailCycles) @(negedge clk);
		if (mismatches == 0 && chars_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* filelist.f */
rtl/nta_pkg.sv
rtl/nta_front.sv
rtl/nta_fifo.sv
rtl/nta_back.sv
rtl/number_to_ascii_formatter.sv
tb/number_to_ascii_formatter_test.sv
